>>> src/cfd_pkg.sv
package cfd_pkg;

  localparam int DATA_W = 16;
  localparam int TAPS_DEF = 64;

  // Item kinds carried on the input tuser bit.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_COEF   = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_DECIMATION   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_LENGTH = 1'b1;

  localparam int DEC_W = 7;
  localparam int LEN_W = 13;
  localparam int PHASE_W = 6;
  localparam int POS_W = 12;
  localparam int CIDX_W = 6;

  localparam logic [DEC_W-1:0] DEC_RESET = 7'd1;
  localparam logic [DEC_W-1:0] DEC_MAX   = 7'd64;
  localparam logic [LEN_W-1:0] LEN_RESET = 13'd512;
  localparam logic [LEN_W-1:0] LEN_MAX   = 13'd4096;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clear;
    logic en;
  } cmac_ctl_t;

endpackage

>>> src/cfd_ram.sv
module cfd_ram #(
  parameter int DEPTH = cfd_pkg::TAPS_DEF,
  parameter int AW    = 6,
  parameter int WIDTH = 2 * cfd_pkg::DATA_W
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    q <= mem[raddr];
  end

endmodule

>>> src/cfd_cmac.sv
module cfd_cmac #(
  parameter int ACC_W = 40
) (
  input  logic                              clk,
  input  logic                              rst,
  input  cfd_pkg::cmac_ctl_t                ctl,
  input  logic signed [cfd_pkg::DATA_W-1:0] tr,
  input  logic signed [cfd_pkg::DATA_W-1:0] ti,
  input  logic signed [cfd_pkg::DATA_W-1:0] hr,
  input  logic signed [cfd_pkg::DATA_W-1:0] hi,
  output logic signed [ACC_W-1:0]           acc_re,
  output logic signed [ACC_W-1:0]           acc_im,
  output logic                              busy
);

  localparam int PW = 2 * cfd_pkg::DATA_W;

  logic signed [PW-1:0] p_rr;
  logic signed [PW-1:0] p_ii;
  logic signed [PW-1:0] p_ri;
  logic signed [PW-1:0] p_ir;
  logic                 pv;

  // Product stage: four 16 x 16 multipliers, registered.
  always_ff @(posedge clk) begin
    p_rr <= tr * hr;
    p_ii <= ti * hi;
    p_ri <= tr * hi;
    p_ir <= ti * hr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= ctl.en;
    end
  end

  // Accumulate stage: real part takes rr - ii, imaginary part ri + ir.
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (pv) begin
      acc_re <= acc_re + ACC_W'(p_rr) - ACC_W'(p_ii);
      acc_im <= acc_im + ACC_W'(p_ri) + ACC_W'(p_ir);
    end
  end

  assign busy = pv;

endmodule

>>> src/complex_fir_decimator_unit.sv
// Complex decimating FIR filter, Q1.15, one complex tap per clock cycle.
// A kept sample has its result in the output register in the same cycle that the block is
// ready again; no new request is taken while a kept sample is in work.
// Kept samples are handled one at a time by the one complex multiply-accumulate unit, and a
// waiting earlier result holds the block; skipped samples and coefficient loads stay in idle.
// Reset (rst, synchronous, active high) clears the sequencer, counters and valid bits at once.
module complex_fir_decimator_unit #(
  parameter int TAPS = cfd_pkg::TAPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input requests.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: sample_re[15:0], sample_im[31:16], coef_index[37:32], coef_re[53:38],
  // coef_im[69:54], zero fill [71:70].
  input  logic [71:0]                   s_axis_tdata,
  // tuser: command (0 = sample, 1 = coefficient load).
  input  logic                          s_axis_tuser,
  // Output requests.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: out_re[15:0], out_im[31:16].
  output logic [31:0]                   m_axis_tdata,
  // tlast: chunk_end.
  output logic                          m_axis_tlast,
  // tuser: clipped.
  output logic                          m_axis_tuser,
  // Configuration writes.
  input  logic                          cfg_we,
  input  logic [cfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cfd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int DW    = cfd_pkg::DATA_W;
  localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int ACC_W = 34 + $clog2(TAPS);

  // Sequencer states.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MAC   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_ROUND = 2'd3;

  // Unpacked input fields.
  logic                           command;
  logic [DW-1:0]                  sample_re;
  logic [DW-1:0]                  sample_im;
  logic [cfd_pkg::CIDX_W-1:0]     coef_index;
  logic [DW-1:0]                  coef_re;
  logic [DW-1:0]                  coef_im;

  assign command    = s_axis_tuser;
  assign sample_re  = s_axis_tdata[15:0];
  assign sample_im  = s_axis_tdata[31:16];
  assign coef_index = s_axis_tdata[37:32];
  assign coef_re    = s_axis_tdata[53:38];
  assign coef_im    = s_axis_tdata[69:54];

  logic [1:0]                  state;
  logic [cfd_pkg::DEC_W-1:0]   decimation;
  logic [cfd_pkg::LEN_W-1:0]   chunk_length;
  logic [cfd_pkg::PHASE_W-1:0] phase;
  logic [cfd_pkg::POS_W-1:0]   chunk_pos;
  logic [AW-1:0]               wr_ptr;
  logic [AW-1:0]               rd_addr;
  logic [AW-1:0]               k;
  logic [TAPS-1:0]             hist_vld;
  logic [TAPS-1:0]             tap_vld;
  logic                        rd_v;
  logic                        hist_q_vld;
  logic                        tap_q_vld;

  logic                        accept;
  logic                        is_sample;
  logic                        coef_ok;
  logic [AW-1:0]               tap_waddr;
  logic [cfd_pkg::DEC_W-1:0]   dec_eff;
  logic [cfd_pkg::LEN_W-1:0]   len_eff;
  logic [cfd_pkg::DEC_W-1:0]   phase_inc;
  logic [cfd_pkg::PHASE_W-1:0] phase_next;
  logic [cfd_pkg::LEN_W-1:0]   pos_inc;
  logic                        last;
  logic                        out_free;

  logic [2*DW-1:0]             hist_q;
  logic [2*DW-1:0]             tap_q;
  logic signed [DW-1:0]        hr;
  logic signed [DW-1:0]        hi;
  logic signed [DW-1:0]        tr;
  logic signed [DW-1:0]        ti;
  cfd_pkg::cmac_ctl_t          cmac_ctl;
  logic signed [ACC_W-1:0]     acc_re;
  logic signed [ACC_W-1:0]     acc_im;
  logic                        cmac_busy;
  logic [DW:0]                 rs_re;
  logic [DW:0]                 rs_im;

  // Round half up, take the floor of the shift by 15, then saturate to 16 bits.
  // The top bit of the result is the saturation flag.
  function automatic logic [DW:0] rnd_sat(input logic signed [ACC_W-1:0] a);
    logic [ACC_W:0]    v;
    logic [ACC_W-15:0] q;
    logic              ovf;
    logic [DW:0]       r;
    v   = {a[ACC_W-1], a} + (ACC_W+1)'(16384);
    q   = v[ACC_W:15];
    ovf = !((&q[ACC_W-15:DW-1]) || !(|q[ACC_W-15:DW-1]));
    if (!ovf) begin
      r = {1'b0, q[DW-1:0]};
    end else if (q[ACC_W-15]) begin
      r = {1'b1, 1'b1, {(DW-1){1'b0}}};
    end else begin
      r = {1'b1, 1'b0, {(DW-1){1'b1}}};
    end
    return r;
  endfunction

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_sample     = (command == cfd_pkg::CMD_SAMPLE);
  assign coef_ok       = (32'(coef_index) < TAPS);
  assign tap_waddr     = AW'(coef_index);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Out-of-range register values are clamped to the nearest legal setting.
  always_comb begin
    if (decimation == '0) begin
      dec_eff = cfd_pkg::DEC_W'(1);
    end else if (decimation > cfd_pkg::DEC_MAX) begin
      dec_eff = cfd_pkg::DEC_MAX;
    end else begin
      dec_eff = decimation;
    end
    if (chunk_length == '0) begin
      len_eff = cfd_pkg::LEN_W'(1);
    end else if (chunk_length > cfd_pkg::LEN_MAX) begin
      len_eff = cfd_pkg::LEN_MAX;
    end else begin
      len_eff = chunk_length;
    end
  end

  // The phase wraps once it reaches the decimation factor, also when the factor was lowered.
  assign phase_inc  = {1'b0, phase} + cfd_pkg::DEC_W'(1);
  assign phase_next = (phase_inc >= dec_eff) ? '0 : phase_inc[cfd_pkg::PHASE_W-1:0];

  assign pos_inc = {1'b0, chunk_pos} + cfd_pkg::LEN_W'(1);
  assign last    = (pos_inc >= len_eff);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      decimation   <= cfd_pkg::DEC_RESET;
      chunk_length <= cfd_pkg::LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cfd_pkg::REG_DECIMATION:   decimation   <= cfg_data[cfd_pkg::DEC_W-1:0];
        cfd_pkg::REG_CHUNK_LENGTH: chunk_length <= cfg_data[cfd_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // The history is a circular buffer: wr_ptr is the slot that the next sample fills, and
  // tap k pairs with the slot k places behind the newest one.
  cfd_ram #(.DEPTH(TAPS), .AW(AW), .WIDTH(2 * DW)) u_hist (
    .clk   (clk),
    .we    (accept && is_sample),
    .waddr (wr_ptr),
    .wdata ({sample_im, sample_re}),
    .raddr (rd_addr),
    .q     (hist_q)
  );

  cfd_ram #(.DEPTH(TAPS), .AW(AW), .WIDTH(2 * DW)) u_taps (
    .clk   (clk),
    .we    (accept && !is_sample && coef_ok),
    .waddr (tap_waddr),
    .wdata ({coef_im, coef_re}),
    .raddr (k),
    .q     (tap_q)
  );

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    hist_q_vld <= hist_vld[rd_addr];
    tap_q_vld  <= tap_vld[k];
  end

  assign hr = hist_q_vld ? hist_q[DW-1:0]    : '0;
  assign hi = hist_q_vld ? hist_q[2*DW-1:DW] : '0;
  assign tr = tap_q_vld  ? tap_q[DW-1:0]     : '0;
  assign ti = tap_q_vld  ? tap_q[2*DW-1:DW]  : '0;

  assign cmac_ctl.clear = accept && is_sample && (phase == '0);
  assign cmac_ctl.en    = rd_v;

  cfd_cmac #(.ACC_W(ACC_W)) u_cmac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (cmac_ctl),
    .tr     (tr),
    .ti     (ti),
    .hr     (hr),
    .hi     (hi),
    .acc_re (acc_re),
    .acc_im (acc_im),
    .busy   (cmac_busy)
  );

  assign rs_re = rnd_sat(acc_re);
  assign rs_im = rnd_sat(acc_im);

  // Sequencer: accept, walk the taps one per cycle for a kept sample, let the pipeline drain, then round.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= '0;
      chunk_pos <= '0;
      wr_ptr    <= '0;
      rd_addr   <= '0;
      k         <= '0;
      hist_vld  <= '0;
      tap_vld   <= '0;
      rd_v      <= 1'b0;
    end else begin
      rd_v <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (is_sample) begin
              hist_vld[wr_ptr] <= 1'b1;
              wr_ptr  <= (wr_ptr == AW'(TAPS - 1)) ? '0 : wr_ptr + AW'(1);
              phase   <= phase_next;
              rd_addr <= wr_ptr;
              k       <= '0;
              if (phase == '0) begin
                state <= S_MAC;
              end
            end else if (coef_ok) begin
              tap_vld[tap_waddr] <= 1'b1;
            end
          end
        end
        S_MAC: begin
          rd_v    <= 1'b1;
          rd_addr <= (rd_addr == '0) ? AW'(TAPS - 1) : rd_addr - AW'(1);
          k       <= k + AW'(1);
          if (k == AW'(TAPS - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_v && !cmac_busy) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          if (out_free) begin
            chunk_pos <= last ? '0 : pos_inc[cfd_pkg::POS_W-1:0];
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: holds a finished result until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_ROUND && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_ROUND && out_free) begin
      m_axis_tdata <= {rs_im[DW-1:0], rs_re[DW-1:0]};
      m_axis_tlast <= last;
      m_axis_tuser <= rs_re[DW] || rs_im[DW];
    end
  end

endmodule
